// File: hw/rtl/qrs_pkg.sv
// Shared types for the quadratic root solver pipeline.
package qrs_pkg;

    // Result kinds reported on the output tuser.
    typedef enum logic [2:0] {
        KIND_NONE   = 3'd0,
        KIND_DOUBLE = 3'd1,
        KIND_TWO    = 3'd2,
        KIND_LINEAR = 3'd3,
        KIND_INF    = 3'd4
    } kind_t;

    // Number of root bits produced by the square root stages.
    localparam int SQ_BITS = 34;

    // Sideband carried through the front and square root stages.
    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic        sa;
        logic        sb;
        logic        sc;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] mc;
    } side_t;

    // Sideband carried through the divider stages.
    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  neg_one;
        logic  neg_two;
    } div_side_t;

endpackage

// File: hw/rtl/qrs_div.sv
// Pipelined dual restoring divider, one quotient bit per stage.
module qrs_div #(
    parameter int NW        = 35,
    parameter int DW        = 33,
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  qrs_pkg::div_side_t        side_in,
    input  logic [NW-1:0]             num_one,
    input  logic [NW-1:0]             num_two,
    input  logic [DW-1:0]             den,
    output qrs_pkg::div_side_t        side_out,
    output logic [NW+FRAC_BITS-1:0]   quo_one,
    output logic [NW+FRAC_BITS-1:0]   quo_two
);
    import qrs_pkg::*;

    localparam int QW = NW + FRAC_BITS;

    div_side_t       side_reg [0:QW];
    logic [NW-1:0]   n1_reg   [0:QW];
    logic [NW-1:0]   n2_reg   [0:QW];
    logic [DW-1:0]   d_reg    [0:QW];
    logic [DW-1:0]   r1_reg   [0:QW];
    logic [DW-1:0]   r2_reg   [0:QW];
    logic [QW-1:0]   q1_reg   [0:QW];
    logic [QW-1:0]   q2_reg   [0:QW];

    // Stage zero is the input itself.
    always_comb
    begin
        side_reg[0] = side_in;
        n1_reg[0]   = num_one;
        n2_reg[0]   = num_two;
        d_reg[0]    = den;
        r1_reg[0]   = '0;
        r2_reg[0]   = '0;
        q1_reg[0]   = '0;
        q2_reg[0]   = '0;
    end

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            localparam int P = QW - 1 - k;
            logic          bit1;
            logic          bit2;
            logic [DW:0]   t1;
            logic [DW:0]   t2;
            logic          ge1;
            logic          ge2;
            logic [DW:0]   s1;
            logic [DW:0]   s2;

            // Next dividend bit: numerator shifted left by the fraction width.
            if (P >= FRAC_BITS)
            begin : g_num
                assign bit1 = n1_reg[k][P-FRAC_BITS];
                assign bit2 = n2_reg[k][P-FRAC_BITS];
            end
            else
            begin : g_zero
                assign bit1 = 1'b0;
                assign bit2 = 1'b0;
            end

            // Trial subtraction for both numerators.
            assign t1  = {r1_reg[k], bit1};
            assign t2  = {r2_reg[k], bit2};
            assign ge1 = t1 >= {1'b0, d_reg[k]};
            assign ge2 = t2 >= {1'b0, d_reg[k]};
            assign s1  = ge1 ? (t1 - {1'b0, d_reg[k]}) : t1;
            assign s2  = ge2 ? (t2 - {1'b0, d_reg[k]}) : t2;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    side_reg[k+1].valid <= 1'b0;
                end
                else if (en)
                begin
                    side_reg[k+1] <= side_reg[k];
                    n1_reg[k+1]   <= n1_reg[k];
                    n2_reg[k+1]   <= n2_reg[k];
                    d_reg[k+1]    <= d_reg[k];
                    r1_reg[k+1]   <= s1[DW-1:0];
                    r2_reg[k+1]   <= s2[DW-1:0];
                    q1_reg[k+1]   <= {q1_reg[k][QW-2:0], ge1};
                    q2_reg[k+1]   <= {q2_reg[k][QW-2:0], ge2};
                end
            end
        end
    endgenerate

    assign side_out = side_reg[QW];
    assign quo_one  = q1_reg[QW];
    assign quo_two  = q2_reg[QW];

    // Both remainders always stay below the divisor.
    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        side_reg[QW].valid && d_reg[QW] != '0 |-> r1_reg[QW] < d_reg[QW])
        else $error("divider remainder not below divisor");
    a_rem2_below: assert property (@(posedge clk) disable iff (!rst_n)
        side_reg[QW].valid && d_reg[QW] != '0 |-> r2_reg[QW] < d_reg[QW])
        else $error("divider second remainder not below divisor");
    a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(side_reg[QW].valid))
        else $error("divider valid moved while stalled");

endmodule

// File: hw/rtl/quadratic_root_solver.sv
// Throughput: one item per cycle while the output is not stalled; 34 square root stages and one divider stage
// per quotient bit each retire one item a cycle.
// A stall on the output freezes the whole pipeline; no item is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
// Top level of the pipelined fixed-point quadratic root solver.
module quadratic_root_solver #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // coef_a[31:0], coef_b[63:32], coef_c[95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // root_one[31:0], root_two[63:32], saturated[64], zero
    output logic [2:0]  m_tuser    // root_kind[2:0]
);
    import qrs_pkg::*;

    localparam int NW = 35;
    localparam int DW = 33;
    localparam int QW = NW + FRAC_BITS;
    localparam int RW = 68;

    logic adv;

    // Output register.
    logic        out_valid_reg;
    kind_t       out_kind_reg;
    logic [31:0] out_r1_reg;
    logic [31:0] out_r2_reg;
    logic        out_sat_reg;

    // The pipeline moves whenever the output slot is free or being taken.
    assign adv      = m_tready || !out_valid_reg;
    assign s_tready = adv;

    // Stage A: register coefficients as sign and magnitude.
    side_t a_side_reg;
    logic [31:0] in_a;
    logic [31:0] in_b;
    logic [31:0] in_c;

    assign in_a = s_tdata[31:0];
    assign in_b = s_tdata[63:32];
    assign in_c = s_tdata[95:64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_side_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            a_side_reg.valid <= s_tvalid;
            a_side_reg.kind  <= KIND_NONE;
            a_side_reg.sa    <= in_a[31];
            a_side_reg.sb    <= in_b[31];
            a_side_reg.sc    <= in_c[31];
            a_side_reg.ma    <= in_a[31] ? (32'd0 - in_a) : in_a;
            a_side_reg.mb    <= in_b[31] ? (32'd0 - in_b) : in_b;
            a_side_reg.mc    <= in_c[31] ? (32'd0 - in_c) : in_c;
        end
    end

    // Stage B: the two products of the discriminant.
    side_t b_side_reg;
    logic [63:0] bb_reg;
    logic [63:0] ac_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_side_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            b_side_reg <= a_side_reg;
            bb_reg     <= 64'(a_side_reg.mb) * 64'(a_side_reg.mb);
            ac_reg     <= 64'(a_side_reg.ma) * 64'(a_side_reg.mc);
        end
    end

    // Stage C: discriminant and result kind.
    side_t                 sq_side_reg [0:SQ_BITS];
    logic [RW-1:0]         sq_rem_reg  [0:SQ_BITS];
    logic [SQ_BITS-1:0]    sq_root_reg [0:SQ_BITS];

    logic [RW-1:0] ac4;
    logic [RW-1:0] bbw;
    logic          mixed;
    logic          disc_neg;
    logic [RW-1:0] disc;
    kind_t         kind_c;
    side_t         side_c;

    always_comb
    begin
        ac4      = {2'b00, ac_reg, 2'b00};
        bbw      = {4'h0, bb_reg};
        mixed    = (b_side_reg.mc != 32'd0) && (b_side_reg.sa != b_side_reg.sc);
        disc_neg = !mixed && (ac4 > bbw);
        disc     = mixed ? (bbw + ac4) : (bbw - ac4);
        priority if (b_side_reg.ma == 32'd0)
        begin
            if (b_side_reg.mb != 32'd0)
                kind_c = KIND_LINEAR;
            else if (b_side_reg.mc == 32'd0)
                kind_c = KIND_INF;
            else
                kind_c = KIND_NONE;
        end
        else if (disc_neg)
            kind_c = KIND_NONE;
        else if (disc == '0)
            kind_c = KIND_DOUBLE;
        else
            kind_c = KIND_TWO;
        side_c      = b_side_reg;
        side_c.kind = kind_c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_side_reg[0].valid <= 1'b0;
        end
        else if (adv)
        begin
            sq_side_reg[0] <= side_c;
            sq_rem_reg[0]  <= disc_neg ? '0 : disc;
            sq_root_reg[0] <= '0;
        end
    end

    // Square root stages: one root bit per stage, most significant first.
    genvar k;
    generate
        for (k = 0; k < SQ_BITS; k++)
        begin : g_sqrt
            localparam int I = SQ_BITS - 1 - k;
            logic [RW-1:0] trial;
            logic          take;

            assign trial = ({{(RW-SQ_BITS){1'b0}}, sq_root_reg[k]} << (I + 1))
                         | ({{(RW-1){1'b0}}, 1'b1} << (2 * I));
            assign take  = trial <= sq_rem_reg[k];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_side_reg[k+1].valid <= 1'b0;
                end
                else if (adv)
                begin
                    sq_side_reg[k+1] <= sq_side_reg[k];
                    sq_rem_reg[k+1]  <= take ? (sq_rem_reg[k] - trial) : sq_rem_reg[k];
                    sq_root_reg[k+1] <= sq_root_reg[k] | ({{(SQ_BITS-1){1'b0}}, take} << I);
                end
            end
        end
    endgenerate

    // Stage E: numerators, divisor and quotient signs.
    side_t         se;
    logic [35:0]   nb;
    logic [35:0]   nc;
    logic [35:0]   sw;
    logic [35:0]   n1;
    logic [35:0]   n2;
    logic [35:0]   m1;
    logic [35:0]   m2;
    logic [DW-1:0] dm;
    logic          dneg;
    div_side_t     e_side_next;

    always_comb
    begin
        se = sq_side_reg[SQ_BITS];
        nb = se.sb ? {4'h0, se.mb} : (36'd0 - {4'h0, se.mb});
        nc = se.sc ? {4'h0, se.mc} : (36'd0 - {4'h0, se.mc});
        sw = {2'b00, sq_root_reg[SQ_BITS]};
        if (se.kind == KIND_LINEAR)
        begin
            n1   = nc;
            n2   = nc;
            dm   = {1'b0, se.mb};
            dneg = se.sb;
        end
        else
        begin
            n1   = nb + sw;
            n2   = nb - sw;
            dm   = {se.ma, 1'b0};
            dneg = se.sa;
        end
        m1 = n1[35] ? (36'd0 - n1) : n1;
        m2 = n2[35] ? (36'd0 - n2) : n2;
        e_side_next.valid   = se.valid;
        e_side_next.kind    = se.kind;
        e_side_next.neg_one = n1[35] ^ dneg;
        e_side_next.neg_two = n2[35] ^ dneg;
    end

    div_side_t     e_side_reg;
    logic [NW-1:0] e_n1_reg;
    logic [NW-1:0] e_n2_reg;
    logic [DW-1:0] e_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_side_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            e_side_reg <= e_side_next;
            e_n1_reg   <= m1[NW-1:0];
            e_n2_reg   <= m2[NW-1:0];
            e_d_reg    <= dm;
        end
    end

    // Divider for both roots.
    div_side_t     dv_side;
    logic [QW-1:0] q1;
    logic [QW-1:0] q2;

    qrs_div #(
        .NW        (NW),
        .DW        (DW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .side_in  (e_side_reg),
        .num_one  (e_n1_reg),
        .num_two  (e_n2_reg),
        .den      (e_d_reg),
        .side_out (dv_side),
        .quo_one  (q1),
        .quo_two  (q2)
    );

    // Sign, saturation and masking of unused roots.
    logic        sat1;
    logic        sat2;
    logic [31:0] v1;
    logic [31:0] v2;
    logic [31:0] r1_next;
    logic [31:0] r2_next;
    logic        sat_next;

    always_comb
    begin
        sat1 = dv_side.neg_one ? (q1 > QW'(33'h080000000)) : (q1 > QW'(32'h7FFFFFFF));
        sat2 = dv_side.neg_two ? (q2 > QW'(33'h080000000)) : (q2 > QW'(32'h7FFFFFFF));
        if (dv_side.neg_one)
            v1 = sat1 ? 32'h80000000 : (32'd0 - q1[31:0]);
        else
            v1 = sat1 ? 32'h7FFFFFFF : q1[31:0];
        if (dv_side.neg_two)
            v2 = sat2 ? 32'h80000000 : (32'd0 - q2[31:0]);
        else
            v2 = sat2 ? 32'h7FFFFFFF : q2[31:0];
        unique case (dv_side.kind)
            KIND_LINEAR:
            begin
                r1_next  = v1;
                r2_next  = 32'd0;
                sat_next = sat1;
            end
            KIND_DOUBLE, KIND_TWO:
            begin
                r1_next  = v1;
                r2_next  = v2;
                sat_next = sat1 | sat2;
            end
            default:
            begin
                r1_next  = 32'd0;
                r2_next  = 32'd0;
                sat_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_side.valid;
            out_kind_reg  <= dv_side.kind;
            out_r1_reg    <= r1_next;
            out_r2_reg    <= r2_next;
            out_sat_reg   <= sat_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_sat_reg, out_r2_reg, out_r1_reg};

    // Kinds without roots report zeros and no clamp.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_kind_reg == KIND_NONE || out_kind_reg == KIND_INF)
        |-> out_r1_reg == 32'd0 && out_r2_reg == 32'd0 && !out_sat_reg)
        else $error("unused roots not zero");
    // A double root reports the same value twice.
    a_double_same: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_DOUBLE |-> out_r1_reg == out_r2_reg)
        else $error("double root halves differ");
    // A linear result has no second root.
    a_linear_r2: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == KIND_LINEAR |-> out_r2_reg == 32'd0)
        else $error("linear result has second root");

endmodule
